>>> sv/crle_pkg.sv
`default_nettype none

package crle_pkg;

    // Coordinate and count width inside the decoder
    localparam int COORD_BITS = 16;
    // Width of coordinate fields on the result stream
    localparam int OUT_BITS   = 16;
    localparam int GRID_BITS  = 13;
    localparam int STATE_BITS = 8;
    localparam int BYTE_BITS  = 8;
    // Compare width wide enough for both coordinates and grid size, plus a carry
    localparam int CMP_BITS   = ((COORD_BITS > GRID_BITS) ? COORD_BITS : GRID_BITS) + 1;

    localparam logic [GRID_BITS-1:0]  GRID_RESET   = GRID_BITS'(200);
    localparam logic [COORD_BITS-1:0] COORD_MAX    = {COORD_BITS{1'b1}};
    localparam logic [BYTE_BITS-1:0]  CHAR_ZERO    = 8'h30;
    localparam logic [BYTE_BITS-1:0]  CHAR_NINE    = 8'h39;
    localparam logic [BYTE_BITS-1:0]  CHAR_DOT     = 8'h2E;
    localparam logic [BYTE_BITS-1:0]  CHAR_DOLLAR  = 8'h24;
    localparam logic [BYTE_BITS-1:0]  STATE_OFFSET = 8'd64;

    // Packed result payload width, rounded up to whole bytes
    localparam int RES_BITS   = 3 * OUT_BITS + STATE_BITS + 1 + 2 * OUT_BITS;
    localparam int TDATA_BITS = ((RES_BITS + 7) / 8) * 8;

    typedef enum logic [1:0] {
        BK_DIGIT,
        BK_SKIP,
        BK_LINE,
        BK_CELL
    } byte_kind_t;

    typedef enum logic {
        KIND_RUN    = 1'b0,
        KIND_EXTENT = 1'b1
    } res_kind_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] start;
        logic [COORD_BITS-1:0] line;
        logic [COORD_BITS-1:0] len;
        logic [STATE_BITS-1:0] state;
        logic                  outside;
    } run_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] width;
        logic [COORD_BITS-1:0] height;
    } ext_t;

    // Everything one input byte produces
    typedef struct packed {
        logic has_run;
        logic has_ext;
        run_t run;
        ext_t ext;
    } entry_t;

    function automatic logic [COORD_BITS-1:0] sat_add(
        input logic [COORD_BITS-1:0] a,
        input logic [COORD_BITS-1:0] b
    );
        logic [COORD_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        sat_add = s[COORD_BITS] ? COORD_MAX : s[COORD_BITS-1:0];
    endfunction

    function automatic logic [OUT_BITS-1:0] to_out(input logic [COORD_BITS-1:0] v);
        to_out = OUT_BITS'(v);
    endfunction

endpackage

`default_nettype wire

>>> sv/cell_pattern_rle_decoder.sv
`default_nettype none

// Channel   Direction  Handshake               Payload
// s_        in         s_tvalid / s_tready     tdata: byte_in; tlast: last
// m_        out        m_tvalid / m_tready     tdata: run and extent fields;
//                                              tuser: kind; tlast: last_result
// cfg_      in         cfg_valid / cfg_ready   cfg_data: grid_size
//
// One byte is taken per cycle while m_ does not stall and no two-beat result
// is draining. A byte is held in the input register, decoded into the result
// register and leaves from there. A last byte that also closes a run gives two
// result beats and holds the input side until the second beat is taken.
// Reset is synchronous, active low, and returns grid_size to 200.
// A stall on m_ holds the result register and, behind it, the input register.

module cell_pattern_rle_decoder (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,

    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [7:0]                         s_tdata,  // [7:0] byte_in
    input  wire logic                               s_tlast,

    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // [15:0] run_start, [31:16] line_number, [47:32] run_length,
    // [55:48] cell_state, [56] outside_grid, [72:57] extent_width,
    // [88:73] extent_height, [95:89] zero
    output logic [crle_pkg::TDATA_BITS-1:0]         m_tdata,
    output logic                                    m_tuser,  // [0] kind
    output logic                                    m_tlast,

    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [crle_pkg::GRID_BITS-1:0]     cfg_data
);

    logic                               in_vld_reg;
    logic [crle_pkg::BYTE_BITS-1:0]     in_byte_reg;
    logic                               in_last_reg;
    logic [crle_pkg::GRID_BITS-1:0]     grid_reg;

    logic             advance;
    logic             buf_full;
    logic             buf_done;
    crle_pkg::entry_t entry;

    // Move the held byte on once the result register is free or draining
    assign advance   = in_vld_reg && (!buf_full || buf_done);
    assign s_tready  = !in_vld_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
            grid_reg   <= crle_pkg::GRID_RESET;
        end else begin
            if (s_tvalid && s_tready) begin
                in_vld_reg <= 1'b1;
            end else if (advance) begin
                in_vld_reg <= 1'b0;
            end
            if (cfg_valid) begin
                grid_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    crle_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .byte_in   (in_byte_reg),
        .last      (in_last_reg),
        .grid_size (grid_reg),
        .entry     (entry)
    );

    crle_outbuf u_outbuf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance),
        .entry    (entry),
        .full     (buf_full),
        .done     (buf_done),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

>>> sv/crle_decode.sv
`default_nettype none

module crle_decode (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              advance,
    input  wire logic [crle_pkg::BYTE_BITS-1:0]    byte_in,
    input  wire logic                              last,
    input  wire logic [crle_pkg::GRID_BITS-1:0]    grid_size,
    output crle_pkg::entry_t                       entry
);

    localparam int CB = crle_pkg::COORD_BITS;
    localparam int MB = crle_pkg::CMP_BITS;

    logic [CB-1:0] pos_reg,     pos_next;
    logic [CB-1:0] line_reg,    line_next;
    logic [CB-1:0] widest_reg,  widest_next;
    logic [CB-1:0] pending_reg, pending_next;
    logic          present_reg, present_next;

    crle_pkg::byte_kind_t kind;
    logic [CB-1:0]   n;
    logic [CB-1:0]   pos_upd, line_upd, widest_upd, pending_upd;
    logic            present_upd;
    logic [CB+3:0]   times_ten;
    logic [3:0]      digit;
    logic [MB-1:0]   run_end;
    logic [MB-1:0]   grid_ext;

    always_comb begin
        if (byte_in >= crle_pkg::CHAR_ZERO && byte_in <= crle_pkg::CHAR_NINE) begin
            kind = crle_pkg::BK_DIGIT;
        end else if (byte_in == crle_pkg::CHAR_DOT) begin
            kind = crle_pkg::BK_SKIP;
        end else if (byte_in == crle_pkg::CHAR_DOLLAR) begin
            kind = crle_pkg::BK_LINE;
        end else begin
            kind = crle_pkg::BK_CELL;
        end
    end

    assign n         = present_reg ? pending_reg : CB'(1);
    assign digit     = 4'(byte_in - crle_pkg::CHAR_ZERO);
    // count * 10 + digit, as two shifts and two adds
    assign times_ten = ({4'b0, pending_reg} << 3) + ({4'b0, pending_reg} << 1)
                       + (CB + 4)'(digit);
    assign grid_ext  = MB'(grid_size);
    assign run_end   = MB'(pos_reg) + MB'(n);

    always_comb begin
        pos_upd     = pos_reg;
        line_upd    = line_reg;
        widest_upd  = widest_reg;
        pending_upd = '0;
        present_upd = 1'b0;
        entry       = '0;

        unique case (kind)
            crle_pkg::BK_DIGIT: begin
                pending_upd = (times_ten[CB+3:CB] != 4'b0) ? crle_pkg::COORD_MAX
                                                           : times_ten[CB-1:0];
                present_upd = 1'b1;
            end
            crle_pkg::BK_SKIP: begin
                pos_upd = crle_pkg::sat_add(pos_reg, n);
            end
            crle_pkg::BK_LINE: begin
                if (pos_reg > widest_reg) begin
                    widest_upd = pos_reg;
                end
                line_upd = crle_pkg::sat_add(line_reg, n);
                pos_upd  = '0;
            end
            crle_pkg::BK_CELL: begin
                entry.has_run     = 1'b1;
                entry.run.start   = pos_reg;
                entry.run.line    = line_reg;
                entry.run.len     = n;
                entry.run.state   = byte_in - crle_pkg::STATE_OFFSET;
                entry.run.outside = (MB'(line_reg) >= grid_ext) || (run_end > grid_ext);
                pos_upd = crle_pkg::sat_add(pos_reg, n);
            end
            default: begin
                pos_upd = pos_reg;
            end
        endcase

        if (last) begin
            entry.has_ext    = 1'b1;
            entry.ext.width  = widest_upd;
            entry.ext.height = line_upd;
        end

        // Start a fresh pattern after the final byte
        pos_next     = last ? '0 : pos_upd;
        line_next    = last ? '0 : line_upd;
        widest_next  = last ? '0 : widest_upd;
        pending_next = last ? '0 : pending_upd;
        present_next = last ? 1'b0 : present_upd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            line_reg    <= '0;
            widest_reg  <= '0;
            pending_reg <= '0;
            present_reg <= 1'b0;
        end else if (advance) begin
            pos_reg     <= pos_next;
            line_reg    <= line_next;
            widest_reg  <= widest_next;
            pending_reg <= pending_next;
            present_reg <= present_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/crle_outbuf.sv
`default_nettype none

module crle_outbuf (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               load,
    input  wire crle_pkg::entry_t                   entry,
    output logic                                    full,
    output logic                                    done,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [crle_pkg::TDATA_BITS-1:0]         m_tdata,
    output logic                                    m_tuser,
    output logic                                    m_tlast
);

    localparam int OB = crle_pkg::OUT_BITS;
    localparam int SB = crle_pkg::STATE_BITS;

    logic             vld_reg,   vld_next;
    logic             phase_reg, phase_next;
    crle_pkg::entry_t ent_reg,   ent_next;

    logic          sel_ext;
    logic          final_beat;
    logic [OB-1:0] f_start, f_line, f_len, f_width, f_height;
    logic [SB-1:0] f_state;
    logic          f_outside;

    // Extent beat follows the run beat, or stands alone
    assign sel_ext    = !ent_reg.has_run || phase_reg;
    assign final_beat = sel_ext || !ent_reg.has_ext;
    assign m_tvalid   = vld_reg;
    assign done       = vld_reg && m_tready && final_beat;
    assign full       = vld_reg;

    always_comb begin
        vld_next   = vld_reg;
        phase_next = phase_reg;
        ent_next   = ent_reg;
        if (vld_reg && m_tready) begin
            if (final_beat) begin
                vld_next   = 1'b0;
                phase_next = 1'b0;
            end else begin
                phase_next = 1'b1;
            end
        end
        if (load) begin
            vld_next   = entry.has_run || entry.has_ext;
            phase_next = 1'b0;
            ent_next   = entry;
        end
    end

    always_comb begin
        f_start   = '0;
        f_line    = '0;
        f_len     = '0;
        f_state   = '0;
        f_outside = 1'b0;
        f_width   = '0;
        f_height  = '0;
        if (sel_ext) begin
            f_width  = crle_pkg::to_out(ent_reg.ext.width);
            f_height = crle_pkg::to_out(ent_reg.ext.height);
        end else begin
            f_start   = crle_pkg::to_out(ent_reg.run.start);
            f_line    = crle_pkg::to_out(ent_reg.run.line);
            f_len     = crle_pkg::to_out(ent_reg.run.len);
            f_state   = ent_reg.run.state;
            f_outside = ent_reg.run.outside;
        end
    end

    assign m_tdata = crle_pkg::TDATA_BITS'({f_height, f_width, f_outside, f_state,
                                            f_len, f_line, f_start});
    assign m_tuser = sel_ext ? crle_pkg::KIND_EXTENT : crle_pkg::KIND_RUN;
    assign m_tlast = final_beat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg   <= 1'b0;
            phase_reg <= 1'b0;
        end else begin
            vld_reg   <= vld_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        ent_reg <= ent_next;
    end

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
`default_nettype none

module tb_top;

    localparam int LIMIT_CYCLES = 300000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES = 120;
    localparam int PHASE_BYTES = 230;
    localparam int unsigned CAP = (1 << crle_pkg::COORD_BITS) - 1;

    typedef struct {
        crle_pkg::res_kind_t             kind;
        logic [crle_pkg::OUT_BITS-1:0]   start;
        logic [crle_pkg::OUT_BITS-1:0]   line;
        logic [crle_pkg::OUT_BITS-1:0]   len;
        logic [crle_pkg::STATE_BITS-1:0] state;
        logic                            outside;
        logic [crle_pkg::OUT_BITS-1:0]   width;
        logic [crle_pkg::OUT_BITS-1:0]   height;
        logic                            last;
    } beat_t;

    typedef struct {
        logic [7:0] ch;
        logic       fin;
        int         ntyped;
        beat_t      w0;
        beat_t      w1;
    } script_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [7:0] s_tdata = '0;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [crle_pkg::TDATA_BITS-1:0] m_tdata;
    logic m_tuser;
    logic m_tlast;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [crle_pkg::GRID_BITS-1:0] cfg_data = '0;

    // decoder state as the block should hold it
    int unsigned grid_edge = crle_pkg::GRID_RESET;
    int unsigned row_pos = 0;
    int unsigned row_idx = 0;
    int unsigned widest = 0;
    int unsigned repeat_cnt = 0;
    bit repeat_seen = 1'b0;

    beat_t beats_due[$];
    script_row_t script[$];
    int errors = 0;
    int bytes_sent = 0;
    int beats_seen = 0;
    int grids_tried = 0;
    int cycles = 0;
    bit calm = 1'b0;
    bit hold_req = 1'b0;

    cell_pattern_rle_decoder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d beats outstanding", cycles,
                     beats_due.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    function automatic beat_t mk_run(int unsigned start, int unsigned line,
                                     int unsigned len, logic [7:0] state,
                                     logic outside, logic last);
        beat_t r;
        r.kind = crle_pkg::KIND_RUN;
        r.start = crle_pkg::OUT_BITS'(start);
        r.line = crle_pkg::OUT_BITS'(line);
        r.len = crle_pkg::OUT_BITS'(len);
        r.state = state;
        r.outside = outside;
        r.width = '0;
        r.height = '0;
        r.last = last;
        return r;
    endfunction

    function automatic beat_t mk_ext(int unsigned w, int unsigned h);
        beat_t r;
        r = mk_run(0, 0, 0, '0, 1'b0, 1'b1);
        r.kind = crle_pkg::KIND_EXTENT;
        r.width = crle_pkg::OUT_BITS'(w);
        r.height = crle_pkg::OUT_BITS'(h);
        return r;
    endfunction

    function automatic int unsigned capped_sum(int unsigned a, int unsigned b);
        return (a + b > CAP) ? CAP : a + b;
    endfunction

    // advance the decoder by one byte; return the beats it should produce
    task automatic decode_byte(input logic [7:0] b, input logic fin,
                               output beat_t r0, output beat_t r1, output int n);
        int unsigned reps;
        int unsigned grown;
        logic outside;
        beat_t ext;
        n = 0;
        if (b >= crle_pkg::CHAR_ZERO && b <= crle_pkg::CHAR_NINE) begin
            grown = repeat_cnt * 10 + int'(b - crle_pkg::CHAR_ZERO);
            repeat_cnt = (grown > CAP) ? CAP : grown;
            repeat_seen = 1'b1;
        end else begin
            reps = repeat_seen ? repeat_cnt : 1;
            if (b == crle_pkg::CHAR_DOT) begin
                row_pos = capped_sum(row_pos, reps);
            end else if (b == crle_pkg::CHAR_DOLLAR) begin
                if (row_pos > widest) widest = row_pos;
                row_idx = capped_sum(row_idx, reps);
                row_pos = 0;
            end else begin
                outside = (row_idx >= grid_edge) || (row_pos + reps > grid_edge);
                r0 = mk_run(row_pos, row_idx, reps, b - crle_pkg::STATE_OFFSET,
                            outside, !fin);
                n = 1;
                row_pos = capped_sum(row_pos, reps);
            end
            repeat_cnt = 0;
            repeat_seen = 1'b0;
        end
        if (fin) begin
            ext = mk_ext(widest, row_idx);
            if (n == 0) r0 = ext;
            else r1 = ext;
            n++;
            row_pos = 0;
            row_idx = 0;
            widest = 0;
            repeat_cnt = 0;
            repeat_seen = 1'b0;
        end
    endtask

    task automatic flag_mismatch(input string msg);
        errors++;
        $display("mismatch at cycle %0d: %s", cycles, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            flag_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
    endtask

    always @(posedge aclk) begin : watch_results
        beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            beats_seen++;
            if (beats_due.size() == 0) begin
                flag_mismatch("result beat with nothing outstanding");
            end else begin
                want = beats_due.pop_front();
                check_field("kind", 32'(m_tuser), 32'(want.kind));
                check_field("run_start", 32'(m_tdata[15:0]), 32'(want.start));
                check_field("line_number", 32'(m_tdata[31:16]), 32'(want.line));
                check_field("run_length", 32'(m_tdata[47:32]), 32'(want.len));
                check_field("cell_state", 32'(m_tdata[55:48]), 32'(want.state));
                check_field("outside_grid", 32'(m_tdata[56]), 32'(want.outside));
                check_field("extent_width", 32'(m_tdata[72:57]), 32'(want.width));
                check_field("extent_height", 32'(m_tdata[88:73]), 32'(want.height));
                check_field("padding", 32'(m_tdata[crle_pkg::TDATA_BITS-1:89]), 32'd0);
                check_field("last_result", 32'(m_tlast), 32'(want.last));
            end
        end
    end

    // receiver: short random stalls, one long hold on request, none when calm
    initial begin : drain_side
        int gap;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
                m_tready = 1'b1;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                gap = $urandom_range(1, 3);
                m_tready = 1'b0;
                repeat (gap) @(negedge aclk);
                m_tready = 1'b1;
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // offer one byte, wait until it is accepted, then queue what it should produce
    task automatic feed(input logic [7:0] b, input logic fin, input int ntyped,
                        input beat_t w0, input beat_t w1);
        int gap;
        beat_t r0;
        beat_t r1;
        int n;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
            @(negedge aclk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata = b;
        s_tlast = fin;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
        decode_byte(b, fin, r0, r1, n);
        if (ntyped > 0) begin
            r0 = w0;
            r1 = w1;
            n = ntyped;
        end
        if (n > 0) beats_due.push_back(r0);
        if (n > 1) beats_due.push_back(r1);
    endtask

    task automatic settle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        s_tlast = 1'b0;
        while (beats_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_grid(input int unsigned v);
        settle();
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_data = crle_pkg::GRID_BITS'(v);
        do @(posedge aclk); while (!cfg_ready);
        grid_edge = v;
        grids_tried++;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic push_count(ref logic [7:0] pat[$]);
        int sel;
        int unsigned v;
        string digits;
        sel = $urandom_range(0, 19);
        if (sel < 10) v = $urandom_range(1, 9);
        else if (sel < 15) v = $urandom_range(10, 99);
        else if (sel < 17) v = 0;
        else if (sel < 19) v = $urandom_range(100, 9999);
        else v = $urandom_range(0, 99999);
        if ($urandom_range(0, 19) == 0) pat.push_back(crle_pkg::CHAR_ZERO);
        digits = $sformatf("%0d", v);
        for (int i = 0; i < digits.len(); i++) pat.push_back(digits[i]);
    endtask

    function automatic logic [7:0] cell_byte();
        logic [7:0] c;
        if ($urandom_range(0, 4) != 0) return 8'("A") + 8'($urandom_range(0, 23));
        do c = 8'($urandom_range(0, 255));
        while ((c >= crle_pkg::CHAR_ZERO && c <= crle_pkg::CHAR_NINE) ||
               c == crle_pkg::CHAR_DOT || c == crle_pkg::CHAR_DOLLAR);
        return c;
    endfunction

    // mostly well-formed patterns with random content, some raw noise
    task automatic play_pattern();
        logic [7:0] pat[$];
        int ntok;
        int pick;
        if ($urandom_range(0, 4) == 0) begin
            ntok = $urandom_range(1, 8);
            repeat (ntok) pat.push_back(8'($urandom_range(0, 255)));
        end else begin
            ntok = $urandom_range(1, 10);
            repeat (ntok) begin
                if ($urandom_range(0, 1) == 1) push_count(pat);
                pick = $urandom_range(0, 9);
                if (pick < 3) pat.push_back(crle_pkg::CHAR_DOT);
                else if (pick < 5) pat.push_back(crle_pkg::CHAR_DOLLAR);
                else pat.push_back(cell_byte());
            end
            // leave a dangling count now and then
            if ($urandom_range(0, 9) == 0) push_count(pat);
        end
        foreach (pat[i]) feed(pat[i], i == pat.size() - 1, 0, mk_ext(0, 0), mk_ext(0, 0));
    endtask

    initial begin : stimulus
        int unsigned grid_plan[7];
        int phase_start;
        beat_t nil;
        nil = mk_ext(0, 0);

        // default grid of 200 throughout the script
        script.push_back('{"A", 1'b0, 1, mk_run(0, 0, 1, 8'd1, 1'b0, 1'b1), nil});
        script.push_back('{crle_pkg::CHAR_ZERO, 1'b0, 0, nil, nil});
        script.push_back('{"B", 1'b0, 1, mk_run(1, 0, 0, 8'd2, 1'b0, 1'b1), nil});
        script.push_back('{crle_pkg::CHAR_DOT, 1'b0, 0, nil, nil});
        repeat (5) script.push_back('{crle_pkg::CHAR_NINE, 1'b0, 0, nil, nil});
        script.push_back('{"C", 1'b0, 1, mk_run(2, 0, CAP, 8'd3, 1'b1, 1'b1), nil});
        script.push_back('{crle_pkg::CHAR_DOLLAR, 1'b0, 0, nil, nil});
        script.push_back('{crle_pkg::CHAR_ZERO + 8'd3, 1'b0, 0, nil, nil});
        script.push_back('{crle_pkg::CHAR_DOLLAR, 1'b0, 0, nil, nil});
        script.push_back('{8'h00, 1'b0, 1, mk_run(0, 4, 1, 8'hC0, 1'b0, 1'b1), nil});
        script.push_back('{8'hFF, 1'b0, 1, mk_run(1, 4, 1, 8'hBF, 1'b0, 1'b1), nil});
        script.push_back('{crle_pkg::CHAR_ZERO + 8'd7, 1'b0, 0, nil, nil});
        script.push_back('{"@", 1'b1, 2, mk_run(2, 4, 7, 8'd0, 1'b0, 1'b0),
                           mk_ext(CAP, 4)});
        script.push_back('{crle_pkg::CHAR_ZERO + 8'd4, 1'b1, 1, mk_ext(0, 0), nil});
        repeat (5) script.push_back('{crle_pkg::CHAR_NINE, 1'b0, 0, nil, nil});
        script.push_back('{crle_pkg::CHAR_DOLLAR, 1'b0, 0, nil, nil});
        script.push_back('{"D", 1'b0, 1, mk_run(0, CAP, 1, 8'd4, 1'b1, 1'b1), nil});
        script.push_back('{crle_pkg::CHAR_DOT, 1'b1, 1, mk_ext(0, CAP), nil});

        repeat (8) @(negedge aclk);
        aresetn = 1'b1;

        foreach (script[i]) feed(script[i].ch, script[i].fin, script[i].ntyped,
                                 script[i].w0, script[i].w1);

        grid_plan = '{0, 1, 8191, 4096, 12, 200, 0};
        grid_plan[6] = $urandom_range(1, 4096);
        foreach (grid_plan[p]) begin
            set_grid(grid_plan[p]);
            if (p == 2) hold_req = 1'b1;
            if (p == 6) calm = 1'b1;
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES) play_pattern();
        end

        settle();
        $display("covered %0d pattern bytes and %0d result beats over %0d grid sizes,",
                 bytes_sent, beats_seen, grids_tried + 1);
        $display("with zero counts, saturated counts and lines, and a long output hold");
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d mismatches", errors);
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

`default_nettype wire
